// ===== rtl/wavhp_pkg.sv =====
// shared types and constants of the wav header parser
// result record, fifo push group, riff tags and status codes; no dependencies
`default_nettype none

package wavhp_pkg;

	// riff tags as they read little-endian from the byte stream
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_BODY       = 32'd16;
	localparam logic [15:0] SUPPORTED_BITS = 16'd16;
	localparam logic [15:0] MAX_CHANNELS   = 16'd2;

	// status codes
	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_READ    = 4'd1;
	localparam logic [3:0] ST_SEEK    = 4'd2;
	localparam logic [3:0] ST_RIFF    = 4'd3;
	localparam logic [3:0] ST_WAVE    = 4'd4;
	localparam logic [3:0] ST_NOFMT   = 4'd5;
	localparam logic [3:0] ST_NODATA  = 4'd6;
	localparam logic [3:0] ST_FMTSIZE = 4'd7;
	localparam logic [3:0] ST_BITS    = 4'd8;
	localparam logic [3:0] ST_CHANS   = 4'd9;
	localparam logic [3:0] ST_ALIGN   = 4'd10;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// result fifo depth; at least four
	localparam int WAVHP_FIFO_DEPTH = 8;

	localparam int TDATA_W = 168;

	typedef struct packed {
		logic               kind;
		logic               last;
		logic signed [15:0] sample;
		logic               channel;
		logic [3:0]         status;
		logic [1:0]         chan_count;
		logic [31:0]        rate_hz;
		logic [31:0]        bytes_per_sec;
		logic [15:0]        format_code;
		logic [31:0]        data_bytes;
		logic [30:0]        frame_count;
	} result_t;

	// up to two results per byte, sample before status
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/wavhp_fifo.sv =====
// result fifo of the wav header parser, takes up to two items per cycle
// depends on wavhp_pkg for result_t and push_t
`default_nettype none

module wavhp_fifo
	import wavhp_pkg::*;
#(
	parameter int DEPTH = WAVHP_FIFO_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire push_t   push,
	input  wire logic    pop_ready,
	output result_t      head,
	output logic         head_valid,
	output logic         room
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   wr_inc1;
	logic [AW-1:0]   wr_inc2;
	logic            pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) r = '0;
		else r = p + AW'(1);
		return r;
	endfunction

	assign wr_inc1    = ptr_inc(wr_q);
	assign wr_inc2    = ptr_inc(wr_inc1);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = head_valid & pop_ready;
	// four free slots: the byte in flight plus one more, up to two results each
	assign room       = (count_q <= CW'(DEPTH - 4));

	// storage writes
	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.r0;
		if (push.v1) mem_q[wr_inc1] <= push.r1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.v1) wr_q <= wr_inc2;
			else if (push.v0) wr_q <= wr_inc1;
			if (pop) rd_q <= ptr_inc(rd_q);
			count_q <= count_q + CW'(push.v0) + CW'(push.v1) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(count_q) + int'(push.v0) + int'(push.v1) - int'(pop) <= DEPTH))
		else $error("result fifo overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.v0) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not lower the fill count");

	a_room_bound: assert property (@(posedge clk) disable iff (!arst_n)
		room |-> (int'(count_q) + 4 <= DEPTH))
		else $error("room flagged with too little space");

endmodule

`default_nettype wire

// ===== rtl/wavhp_parser.sv =====
// byte-level riff/wave walker: input register, chunk state and result forming
// depends on wavhp_pkg for tags, status codes and push_t
`default_nettype none

module wavhp_parser
	import wavhp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eof,
	output push_t           push
);

	typedef enum logic [5:0] {
		PH_HEADER   = 6'b000001,
		PH_CHUNK    = 6'b000010,
		PH_FMT      = 6'b000100,
		PH_FMT_SKIP = 6'b001000,
		PH_SKIP     = 6'b010000,
		PH_DATA     = 6'b100000
	} phase_t;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	// walker state
	phase_t      phase_q, phase_n;
	logic [3:0]  pos_q, pos_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] size_q, size_n;
	logic [31:0] remain_q, remain_n;
	logic [15:0] afmt_q, afmt_n;
	logic [15:0] chans_q, chans_n;
	logic [15:0] align_q, align_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] brate_q, brate_n;
	logic        found_q, found_n;
	logic [31:0] dlen_q, dlen_n;
	logic [7:0]  hold_q, hold_n;
	logic        toggle_q, toggle_n;
	logic        finished_q, finished_n;

	logic [3:0]  err;
	logic [3:0]  chk;
	logic        smp_v;
	logic [15:0] smp_val;
	logic        smp_ch;
	logic        st_v;
	logic [3:0]  st_code;
	logic [31:0] frames;
	result_t     smp_res;
	result_t     st_res;

	function automatic logic [3:0] fmt_check(input logic [15:0] bits, input logic [15:0] ch,
		input logic [15:0] align);
		logic [3:0] r;
		if (bits != SUPPORTED_BITS) r = ST_BITS;
		else if (ch < 16'd1 || ch > MAX_CHANNELS) r = ST_CHANS;
		else if (align != {ch[14:0], 1'b0}) r = ST_ALIGN;
		else r = ST_OK;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
			eof_s1  <= in_eof;
		end
	end

	// one step of the walk for the registered byte
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		tag_n    = tag_q;
		size_n   = size_q;
		remain_n = remain_q;
		afmt_n   = afmt_q;
		chans_n  = chans_q;
		align_n  = align_q;
		bits_n   = bits_q;
		rate_n   = rate_q;
		brate_n  = brate_q;
		found_n  = found_q;
		dlen_n   = dlen_q;
		hold_n   = hold_q;
		toggle_n = toggle_q;
		err      = ST_OK;
		chk      = ST_OK;
		smp_v    = 1'b0;
		smp_val  = {byte_s1, hold_q};
		smp_ch   = toggle_q;
		st_v     = 1'b0;
		st_code  = ST_OK;

		if (valid_s1 && !finished_q) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q < 4'd4) tag_n = {byte_s1, tag_q[31:8]};
					else if (pos_q >= 4'd8) size_n = {byte_s1, size_q[31:8]};
					pos_n = pos_q + 4'd1;
					if (pos_q == 4'd11) begin
						if (tag_n != TAG_RIFF) err = ST_RIFF;
						else if (size_n != TAG_WAVE) err = ST_WAVE;
						else begin
							phase_n = PH_CHUNK;
							pos_n   = '0;
						end
					end
				end
				PH_CHUNK: begin
					if (pos_q < 4'd4) tag_n = {byte_s1, tag_q[31:8]};
					else size_n = {byte_s1, size_q[31:8]};
					pos_n = pos_q + 4'd1;
					if (pos_q == 4'd7) begin
						pos_n = '0;
						if (tag_n == TAG_FMT) begin
							if (size_n < FMT_BODY) err = ST_FMTSIZE;
							else begin
								remain_n = size_n - FMT_BODY;
								phase_n  = PH_FMT;
							end
						end else if (tag_n == TAG_DATA) begin
							dlen_n   = size_n;
							remain_n = size_n;
							toggle_n = 1'b0;
							phase_n  = PH_DATA;
							if (size_n == '0) begin
								st_v    = 1'b1;
								st_code = found_q ? ST_OK : ST_NOFMT;
							end
						end else begin
							remain_n = size_n;
							phase_n  = (size_n == '0) ? PH_CHUNK : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					// body: format, channels, rate, byte rate, align, bits
					case (pos_q)
						4'd0:    afmt_n[7:0]   = byte_s1;
						4'd1:    afmt_n[15:8]  = byte_s1;
						4'd2:    chans_n[7:0]  = byte_s1;
						4'd3:    chans_n[15:8] = byte_s1;
						4'd4, 4'd5, 4'd6, 4'd7:
							rate_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
						4'd8, 4'd9, 4'd10, 4'd11:
							brate_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
						4'd12:   align_n[7:0]  = byte_s1;
						4'd13:   align_n[15:8] = byte_s1;
						4'd14:   bits_n[7:0]   = byte_s1;
						default: bits_n[15:8]  = byte_s1;
					endcase
					pos_n = pos_q + 4'd1;
					if (pos_q == 4'd15) begin
						pos_n = '0;
						if (remain_q == '0) begin
							chk = fmt_check(bits_n, chans_n, align_n);
							if (chk == ST_OK) begin
								found_n = 1'b1;
								phase_n = PH_CHUNK;
							end else err = chk;
						end else phase_n = PH_FMT_SKIP;
					end
				end
				PH_FMT_SKIP: begin
					remain_n = remain_q - 32'd1;
					if (remain_n == '0) begin
						chk = fmt_check(bits_q, chans_q, align_q);
						if (chk == ST_OK) begin
							found_n = 1'b1;
							phase_n = PH_CHUNK;
							pos_n   = '0;
						end else err = chk;
					end
				end
				PH_SKIP: begin
					remain_n = remain_q - 32'd1;
					if (remain_n == '0) begin
						phase_n = PH_CHUNK;
						pos_n   = '0;
					end
				end
				PH_DATA: begin
					remain_n = remain_q - 32'd1;
					if (found_q) begin
						if (!pos_q[0]) hold_n = byte_s1;
						else begin
							smp_v = 1'b1;
							if (chans_q == 16'd2) toggle_n = ~toggle_q;
						end
					end
					pos_n = pos_q + 4'd1;
					if (remain_n == '0) begin
						st_v    = 1'b1;
						st_code = found_q ? ST_OK : ST_NOFMT;
					end
				end
				default: begin
					phase_n = PH_HEADER;
				end
			endcase
			if (err != ST_OK) begin
				st_v    = 1'b1;
				st_code = err;
			end
		end

		// truncation status by phase
		if (valid_s1 && eof_s1 && !finished_q && !st_v) begin
			st_v = 1'b1;
			if (phase_n == PH_HEADER || phase_n == PH_FMT) st_code = ST_READ;
			else if (phase_n == PH_CHUNK)
				st_code = (pos_n < 4'd4) ? (found_n ? ST_NODATA : ST_NOFMT) : ST_READ;
			else st_code = ST_SEEK;
		end
	end

	// result records, status fields from the updated state
	always_comb begin
		if (found_n) frames = (chans_n == 16'd2) ? (dlen_n >> 2) : (dlen_n >> 1);
		else frames = '0;

		smp_res         = '0;
		smp_res.kind    = KIND_SAMPLE;
		smp_res.sample  = smp_val;
		smp_res.channel = smp_ch;

		st_res               = '0;
		st_res.kind          = KIND_STATUS;
		st_res.last          = 1'b1;
		st_res.status        = st_code;
		st_res.chan_count    = chans_n[1:0];
		st_res.rate_hz       = rate_n;
		st_res.bytes_per_sec = brate_n;
		st_res.format_code   = afmt_n;
		st_res.data_bytes    = dlen_n;
		st_res.frame_count   = frames[30:0];

		push.v0 = smp_v | st_v;
		push.v1 = smp_v & st_v;
		push.r0 = smp_v ? smp_res : st_res;
		push.r1 = st_res;
	end

	assign finished_n = finished_q | st_v;

	// state update; end of file returns to reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			tag_q      <= '0;
			size_q     <= '0;
			remain_q   <= '0;
			afmt_q     <= '0;
			chans_q    <= '0;
			align_q    <= '0;
			bits_q     <= '0;
			rate_q     <= '0;
			brate_q    <= '0;
			found_q    <= 1'b0;
			dlen_q     <= '0;
			hold_q     <= '0;
			toggle_q   <= 1'b0;
			finished_q <= 1'b0;
		end else if (valid_s1 && eof_s1) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			tag_q      <= '0;
			size_q     <= '0;
			remain_q   <= '0;
			afmt_q     <= '0;
			chans_q    <= '0;
			align_q    <= '0;
			bits_q     <= '0;
			rate_q     <= '0;
			brate_q    <= '0;
			found_q    <= 1'b0;
			dlen_q     <= '0;
			hold_q     <= '0;
			toggle_q   <= 1'b0;
			finished_q <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			tag_q      <= tag_n;
			size_q     <= size_n;
			remain_q   <= remain_n;
			afmt_q     <= afmt_n;
			chans_q    <= chans_n;
			align_q    <= align_n;
			bits_q     <= bits_n;
			rate_q     <= rate_n;
			brate_q    <= brate_n;
			found_q    <= found_n;
			dlen_q     <= dlen_n;
			hold_q     <= hold_n;
			toggle_q   <= toggle_n;
			finished_q <= finished_n;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && push.r0.kind == KIND_SAMPLE && push.r1.kind == KIND_STATUS))
		else $error("second result without a leading sample");

	a_quiet_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !push.v0)
		else $error("result after the file status");

	a_status_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !eof_s1 && push.v0 && push.r0.kind == KIND_STATUS) |=> finished_q)
		else $error("status issued but walk not finished");

	a_samples_need_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.kind == KIND_SAMPLE) |-> (found_q && phase_q == PH_DATA))
		else $error("sample outside an accepted data chunk");

endmodule

`default_nettype wire

// ===== rtl/wav_header_parser.sv =====
// wav header parser: one file byte per item in, samples and a final status out
// path: results of an item pass the input register, then the result fifo, before they are offered
// throughput: one byte per cycle; s_tready drops only while the result fifo
//   holds more than FIFO_DEPTH-4 items (a byte can add a sample and a status)
// reset: arst_n clears walk state and fifo at once; end of file also restarts
`default_nettype none

module wav_header_parser
	import wavhp_pkg::*;
#(
	parameter int FIFO_DEPTH = WAVHP_FIFO_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // byte_value[7:0]
	input  wire logic               s_tlast,   // end_of_file
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // sample[15:0], channel[16], status[20:17],
	                                           // chan_count[22:21], rate_hz[54:23],
	                                           // bytes_per_sec[86:55], format_code[102:87],
	                                           // data_bytes[134:103], frame_count[165:135]
	output logic                    m_tuser,   // kind
	output logic                    m_tlast    // last
);

	push_t   push;
	result_t head;
	logic    room;

	assign s_tready = room;

	wavhp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid & s_tready),
		.in_byte  (s_tdata),
		.in_eof   (s_tlast),
		.push     (push)
	);

	wavhp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_ready  (m_tready),
		.head       (head),
		.head_valid (m_tvalid),
		.room       (room)
	);

	// pack the head item onto the master side
	assign m_tdata = {2'b00, head.frame_count, head.data_bytes, head.format_code,
		head.bytes_per_sec, head.rate_hz, head.chan_count, head.status,
		head.channel, head.sample};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== tb/wav_header_parser_checker.sv =====
// checker of the wav header parser: predicts results from accepted bytes and compares
// depends on wavhp_pkg for the result record, tags and status codes
`timescale 1ns / 100ps

module wav_header_parser_checker
	import wavhp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [7:0]         s_tdata,   // byte_value[7:0]
	input  wire logic               s_tlast,   // end_of_file
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [TDATA_W-1:0] m_tdata,   // sample[15:0], channel[16], status[20:17],
	                                           // chan_count[22:21], rate_hz[54:23],
	                                           // bytes_per_sec[86:55], format_code[102:87],
	                                           // data_bytes[134:103], frame_count[165:135]
	input  wire logic               m_tuser,   // kind
	input  wire logic               m_tlast,   // last
	output int                      mismatches,
	output int                      outstanding
);

	typedef enum logic [5:0] {
		WALK_HEADER   = 6'b000001,
		WALK_CHUNK    = 6'b000010,
		WALK_FMT      = 6'b000100,
		WALK_FMT_SKIP = 6'b001000,
		WALK_SKIP     = 6'b010000,
		WALK_DATA     = 6'b100000
	} walk_phase_t;

	// predicted walk state
	walk_phase_t walk_phase;
	logic [31:0] walk_pos;
	logic [31:0] tag_acc;
	logic [31:0] size_acc;
	logic [31:0] bytes_left;
	logic [63:0] fmt_words;   // format, channels, align, bits
	logic [63:0] rate_words;  // sample rate, byte rate
	logic        have_fmt;
	logic [31:0] data_len;
	logic [7:0]  lo_hold;
	logic        chan_sel;
	logic        done;

	result_t     expected_q[$];
	result_t     got;
	result_t     want;

	function automatic logic [15:0] fmt_word(input int idx);
		return fmt_words[16*idx +: 16];
	endfunction

	task automatic clear_walk();
		walk_phase = WALK_HEADER;
		walk_pos   = '0;
		tag_acc    = '0;
		size_acc   = '0;
		bytes_left = '0;
		fmt_words  = '0;
		rate_words = '0;
		have_fmt   = 1'b0;
		data_len   = '0;
		lo_hold    = '0;
		chan_sel   = 1'b0;
		done       = 1'b0;
	endtask

	task automatic start_chunk();
		walk_phase = WALK_CHUNK;
		walk_pos   = '0;
	endtask

	task automatic queue_status(input logic [3:0] code);
		result_t     r;
		logic [15:0] ch;
		logic [31:0] frames;
		r      = '0;
		ch     = fmt_word(1);
		frames = have_fmt ? (data_len >> ((ch == 16'd2) ? 2 : 1)) : 32'd0;
		r.kind          = KIND_STATUS;
		r.last          = 1'b1;
		r.status        = code;
		r.chan_count    = ch[1:0];
		r.rate_hz       = rate_words[31:0];
		r.bytes_per_sec = rate_words[63:32];
		r.format_code   = fmt_word(0);
		r.data_bytes    = data_len;
		r.frame_count   = frames[30:0];
		expected_q.push_back(r);
		done = 1'b1;
	endtask

	task automatic queue_sample(input logic [15:0] value, input logic ch);
		result_t r;
		r         = '0;
		r.kind    = KIND_SAMPLE;
		r.sample  = value;
		r.channel = ch;
		expected_q.push_back(r);
	endtask

	// fmt checks once the whole chunk is in; ST_OK when accepted
	task automatic judge_format(output logic [3:0] code);
		logic [15:0] ch;
		ch = fmt_word(1);
		if (fmt_word(3) != SUPPORTED_BITS)
			code = ST_BITS;
		else if (ch < 16'd1 || ch > MAX_CHANNELS)
			code = ST_CHANS;
		else if (fmt_word(2) != ch * 16'd2)
			code = ST_ALIGN;
		else begin
			code     = ST_OK;
			have_fmt = 1'b1;
			start_chunk();
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eof);
		logic [3:0] err;
		int         p;
		err = ST_OK;
		if (!done) begin
			case (walk_phase)
				WALK_HEADER: begin
					if (walk_pos < 4)
						tag_acc = {b, tag_acc[31:8]};
					else if (walk_pos >= 8)
						size_acc = {b, size_acc[31:8]};
					walk_pos++;
					if (walk_pos == 12) begin
						if (tag_acc != TAG_RIFF)
							err = ST_RIFF;
						else if (size_acc != TAG_WAVE)
							err = ST_WAVE;
						else
							start_chunk();
					end
				end
				WALK_CHUNK: begin
					if (walk_pos < 4)
						tag_acc = {b, tag_acc[31:8]};
					else
						size_acc = {b, size_acc[31:8]};
					walk_pos++;
					if (walk_pos == 8) begin
						walk_pos = '0;
						if (tag_acc == TAG_FMT) begin
							if (size_acc < FMT_BODY)
								err = ST_FMTSIZE;
							else begin
								bytes_left = size_acc - FMT_BODY;
								walk_phase = WALK_FMT;
							end
						end else if (tag_acc == TAG_DATA) begin
							data_len   = size_acc;
							bytes_left = size_acc;
							chan_sel   = 1'b0;
							walk_phase = WALK_DATA;
							if (bytes_left == 0)
								queue_status(have_fmt ? ST_OK : ST_NOFMT);
						end else begin
							bytes_left = size_acc;
							walk_phase = WALK_SKIP;
							if (bytes_left == 0)
								start_chunk();
						end
					end
				end
				WALK_FMT: begin
					p = walk_pos[3:0];
					if (p < 4)
						fmt_words[8*p +: 8] = b;
					else if (p < 12)
						rate_words[8*(p-4) +: 8] = b;
					else
						fmt_words[8*(p-8) +: 8] = b;
					walk_pos++;
					if (walk_pos == FMT_BODY) begin
						walk_pos = '0;
						if (bytes_left == 0)
							judge_format(err);
						else
							walk_phase = WALK_FMT_SKIP;
					end
				end
				WALK_FMT_SKIP: begin
					bytes_left--;
					if (bytes_left == 0)
						judge_format(err);
				end
				WALK_SKIP: begin
					bytes_left--;
					if (bytes_left == 0)
						start_chunk();
				end
				default: begin
					bytes_left--;
					if (have_fmt) begin
						if (!walk_pos[0])
							lo_hold = b;
						else begin
							queue_sample({b, lo_hold}, chan_sel);
							if (fmt_word(1) == 16'd2)
								chan_sel = ~chan_sel;
						end
					end
					walk_pos++;
					if (bytes_left == 0)
						queue_status(have_fmt ? ST_OK : ST_NOFMT);
				end
			endcase
			if (err != ST_OK)
				queue_status(err);
		end

		// end of file: truncation code by phase, then back to a fresh file
		if (eof) begin
			if (!done) begin
				case (walk_phase)
					WALK_HEADER, WALK_FMT: queue_status(ST_READ);
					WALK_CHUNK: begin
						if (walk_pos < 4)
							queue_status(have_fmt ? ST_NODATA : ST_NOFMT);
						else
							queue_status(ST_READ);
					end
					default: queue_status(ST_SEEK);
				endcase
			end
			clear_walk();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
	                           input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// predict on accepted bytes, compare accepted results with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			expected_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got               = '0;
				got.kind          = m_tuser;
				got.last          = m_tlast;
				got.sample        = m_tdata[15:0];
				got.channel       = m_tdata[16];
				got.status        = m_tdata[20:17];
				got.chan_count    = m_tdata[22:21];
				got.rate_hz       = m_tdata[54:23];
				got.bytes_per_sec = m_tdata[86:55];
				got.format_code   = m_tdata[102:87];
				got.data_bytes    = m_tdata[134:103];
				got.frame_count   = m_tdata[165:135];
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected: kind %0d status %0d",
					       got.kind, got.status);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("last", want.last, got.last);
					check_field("sample", want.sample, got.sample);
					check_field("channel", want.channel, got.channel);
					check_field("status", want.status, got.status);
					check_field("chan_count", want.chan_count, got.chan_count);
					check_field("rate_hz", want.rate_hz, got.rate_hz);
					check_field("bytes_per_sec", want.bytes_per_sec, got.bytes_per_sec);
					check_field("format_code", want.format_code, got.format_code);
					check_field("data_bytes", want.data_bytes, got.data_bytes);
					check_field("frame_count", want.frame_count, got.frame_count);
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== tb/wav_header_parser_test.sv =====
// top of the wav header parser testbench: clock, reset, file byte stimulus and verdict
// depends on wavhp_pkg, wav_header_parser and wav_header_parser_checker
`timescale 1ns / 100ps

module wav_header_parser_test;
	import wavhp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TOTAL_BYTES  = 1150;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	int          mismatches;
	int          outstanding;
	int          cycles;
	int          ready_left = 0;
	int          ready_roll;
	bit          calm;
	logic [7:0]  file_bytes[$];
	bit          file_ends[$];

	wav_header_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	wav_header_parser_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 50 MHz clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// file building helpers
	task automatic add_byte(input logic [7:0] v);
		file_bytes.push_back(v);
		file_ends.push_back(1'b0);
	endtask

	task automatic add_le16(input logic [15:0] v);
		add_byte(v[7:0]);
		add_byte(v[15:8]);
	endtask

	task automatic add_le32(input logic [31:0] v);
		add_le16(v[15:0]);
		add_le16(v[31:16]);
	endtask

	task automatic close_file();
		file_ends[file_ends.size()-1] = 1'b1;
	endtask

	task automatic add_header(input logic [31:0] riff, input logic [31:0] wave);
		add_le32(riff);
		add_le32($urandom);
		add_le32(wave);
	endtask

	task automatic add_chunk(input logic [31:0] tag, input logic [31:0] size, input int nbytes);
		add_le32(tag);
		add_le32(size);
		repeat (nbytes) add_byte(8'($urandom));
	endtask

	// fmt chunk; the body is written only when the size allows it
	task automatic add_fmt(input logic [31:0] size, input logic [15:0] fmt_tag,
	                       input logic [15:0] chans, input logic [31:0] rate,
	                       input logic [31:0] brate, input logic [15:0] align,
	                       input logic [15:0] bits, input int extra);
		add_le32(TAG_FMT);
		add_le32(size);
		if (size >= FMT_BODY) begin
			add_le16(fmt_tag);
			add_le16(chans);
			add_le32(rate);
			add_le32(brate);
			add_le16(align);
			add_le16(bits);
			repeat (extra) add_byte(8'($urandom));
		end
	endtask

	task automatic add_good_fmt(input logic [15:0] chans);
		add_fmt(FMT_BODY, 16'd1, chans, 32'd44100, 32'd44100 * chans * 2, chans * 16'd2,
		        SUPPORTED_BITS, 0);
	endtask

	// fmt chunk, mostly valid, sometimes broken in one way
	task automatic add_random_fmt();
		int          roll;
		int          extra;
		logic [15:0] chans;
		logic [15:0] align;
		logic [15:0] bits;
		logic [15:0] fmt_tag;
		roll    = $urandom_range(0, 99);
		chans   = 16'($urandom_range(1, 2));
		align   = chans * 16'd2;
		bits    = SUPPORTED_BITS;
		fmt_tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
		extra   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (roll < 4)
			chans = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4));
		else if (roll < 8)
			bits = 16'($urandom);
		else if (roll < 12)
			align = 16'($urandom);
		if (roll >= 12 && roll < 15) begin
			add_le32(TAG_FMT);
			add_le32($urandom_range(0, 15));
		end else if (roll >= 15 && roll < 17)
			add_fmt($urandom | 32'h0100_0000, fmt_tag, chans, $urandom, $urandom, align, bits,
			        $urandom_range(0, 5));
		else
			add_fmt(FMT_BODY + extra, fmt_tag, chans, $urandom, $urandom, align, bits, extra);
	endtask

	// one random file: mostly well formed, some noise, some broken or cut short
	task automatic add_random_file();
		int start;
		int roll;
		int dlen;
		int cut;
		start = file_bytes.size();
		roll  = $urandom_range(0, 99);
		if (roll < 5) begin
			repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
		end else begin
			add_header((roll < 9) ? $urandom : TAG_RIFF,
			           (roll >= 9 && roll < 12) ? $urandom : TAG_WAVE);
			if ($urandom_range(0, 3) == 0)
				add_chunk($urandom_range(0, 1) ? TAG_LIST : 32'($urandom) | 32'h1,
				          $urandom_range(0, 5), 0);
			// sized chunk: a LIST chunk with as many body bytes as its size says
			if ($urandom_range(0, 3) == 0) begin
				dlen = $urandom_range(0, 6);
				add_chunk(TAG_LIST, dlen, dlen);
			end
			if ($urandom_range(0, 9) != 0)
				add_random_fmt();
			if ($urandom_range(0, 9) == 0)
				add_random_fmt();
			if ($urandom_range(0, 19) == 0)
				add_chunk(TAG_LIST, $urandom | 32'h0001_0000, $urandom_range(0, 6));
			if ($urandom_range(0, 14) == 0)
				add_chunk(TAG_DATA, $urandom, $urandom_range(0, 9));
			else begin
				dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
				add_chunk(TAG_DATA, dlen, dlen);
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, file_bytes.size() - start);
				while (file_bytes.size() > start + cut) begin
					void'(file_bytes.pop_back());
					void'(file_ends.pop_back());
				end
			end
		end
		close_file();
	endtask

	// directed files: extremes and each special case of the walk
	task automatic add_directed_files();
		// mono, extreme samples, end of file on the last data byte
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd1);
		add_le32(TAG_DATA);
		add_le32(32'd4);
		add_le16(16'h8000);
		add_le16(16'h7FFF);
		close_file();
		// stereo after empty and short unknown chunks, fmt extras, odd data size
		add_header(TAG_RIFF, TAG_WAVE);
		add_chunk(TAG_LIST, 32'd0, 0);
		add_chunk(TAG_LIST, 32'd3, 3);
		add_fmt(32'd18, 16'hFFFF, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd4,
		        SUPPORTED_BITS, 2);
		add_le32(TAG_DATA);
		add_le32(32'd5);
		add_le16(16'h0000);
		add_le16(16'hFFFF);
		add_byte(8'hAA);
		add_byte(8'h00);
		add_byte(8'hFF);
		close_file();
		// truncated header, and a one-byte file
		repeat (5) add_byte(8'hFF);
		close_file();
		add_byte(8'h00);
		close_file();
		// bad riff tag, bad wave tag
		add_header(32'h0000_0000, TAG_WAVE);
		add_byte(8'h00);
		close_file();
		add_header(TAG_RIFF, 32'hFFFF_FFFF);
		close_file();
		// end of file inside a chunk id, without and with a valid fmt
		add_header(TAG_RIFF, TAG_WAVE);
		add_le16(16'h6D66);
		close_file();
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd2);
		add_byte(8'h64);
		close_file();
		// end of file inside a chunk size
		add_header(TAG_RIFF, TAG_WAVE);
		add_le32(TAG_DATA);
		add_le16(16'h0000);
		close_file();
		// fmt chunk too short
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(32'd15, 16'd1, 16'd1, 32'd0, 32'd0, 16'd2, SUPPORTED_BITS, 0);
		add_byte(8'h5A);
		close_file();
		// end of file inside the fmt body
		add_header(TAG_RIFF, TAG_WAVE);
		add_le32(TAG_FMT);
		add_le32(FMT_BODY);
		repeat (7) add_byte(8'($urandom));
		close_file();
		// unsupported bits, channel counts and block align
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(FMT_BODY, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd2, 16'd8, 0);
		close_file();
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(FMT_BODY, 16'd1, 16'd0, 32'd8000, 32'd0, 16'd0, SUPPORTED_BITS, 0);
		close_file();
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(FMT_BODY, 16'd1, 16'd3, 32'd8000, 32'd0, 16'd6, SUPPORTED_BITS, 0);
		close_file();
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(FMT_BODY, 16'd1, 16'd2, 32'd8000, 32'd0, 16'd2, SUPPORTED_BITS, 0);
		close_file();
		// end of file among the fmt extra bytes
		add_header(TAG_RIFF, TAG_WAVE);
		add_fmt(32'd20, 16'd1, 16'd1, 32'd8000, 32'd16000, 16'd2, SUPPORTED_BITS, 2);
		close_file();
		// data without fmt
		add_header(TAG_RIFF, TAG_WAVE);
		add_chunk(TAG_DATA, 32'd4, 4);
		close_file();
		// empty data chunk
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd1);
		add_chunk(TAG_DATA, 32'd0, 0);
		close_file();
		// later fmt replaces the earlier one
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd1);
		add_good_fmt(16'd2);
		add_chunk(TAG_DATA, 32'd8, 8);
		close_file();
		// later fmt rejected after a valid one
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd2);
		add_fmt(FMT_BODY, 16'd1, 16'd2, 32'd8000, 32'd0, 16'd4, 16'd24, 0);
		close_file();
		// data cut short after some samples, skipped chunk cut short
		add_header(TAG_RIFF, TAG_WAVE);
		add_good_fmt(16'd2);
		add_chunk(TAG_DATA, 32'hFFFF_FFFF, 6);
		close_file();
		add_header(TAG_RIFF, TAG_WAVE);
		add_chunk(TAG_LIST, 32'd1000, 3);
		close_file();
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// result side: random stalls, mostly short, with long ready stretches
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 50) begin
				m_tready   <= 1'b1;
				ready_left <= $urandom_range(0, 15);
			end else if (ready_roll < 58) begin
				m_tready   <= 1'b1;
				ready_left <= $urandom_range(60, 200);
			end else if (ready_roll < 88) begin
				m_tready   <= 1'b0;
				ready_left <= $urandom_range(0, 2);
			end else if (ready_roll < 97) begin
				m_tready   <= 1'b0;
				ready_left <= $urandom_range(3, 12);
			end else begin
				m_tready   <= 1'b0;
				ready_left <= $urandom_range(20, 50);
			end
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// byte stimulus and verdict
	initial begin
		int gap;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		arst_n   <= 1'b0;
		calm     = 1'b0;
		add_directed_files();
		while (file_bytes.size() < TOTAL_BYTES)
			add_random_file();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (file_bytes[i]) begin
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= file_bytes[i];
			s_tlast  <= file_ends[i];
			do @(posedge clk); while (!s_tready);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
